### hdl/lss_pkg.sv
// Shared constants, codes and types for the LIFO stack with search.
package lss_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  // Fixed result field widths
  localparam int OUT_POS_W = 6;
  localparam int OUT_CNT_W = 7;

  // Match search tree: groups of eight cells
  localparam int GRP     = 8;
  localparam int GRP_W   = 3;
  localparam int NUM_GRP = (STACK_DEPTH + GRP - 1) / GRP;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic                     shift_dn;
    logic                     shift_up;
    logic                     cmp_en;
    logic signed [DATA_W-1:0] cmp_value;
  } cell_ctrl_t;

endpackage

### hdl/lss_cell.sv
// One stack cell: holds a word, shifts with its neighbors, compares on search.
module lss_cell (
  input  logic                             clk,
  input  lss_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic signed [lss_pkg::DATA_W-1:0] from_above,
  input  logic signed [lss_pkg::DATA_W-1:0] from_below,
  output logic signed [lss_pkg::DATA_W-1:0] data,
  output logic                             hit
);

  logic signed [lss_pkg::DATA_W-1:0] data_r;
  logic                              hit_r;

  // Take the upper neighbor's word on push, the lower one's on pop
  always_ff @(posedge clk) begin
    if (ctrl.shift_dn) begin
      data_r <= from_above;
    end else if (ctrl.shift_up) begin
      data_r <= from_below;
    end
  end

  // Latch the match flag for a search
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= occupied && (data_r == ctrl.cmp_value);
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

### hdl/lss_first_hit.sv
// Registered two-level search for the first set hit flag, counted from the top.
module lss_first_hit (
  input  logic                             clk,
  input  logic [lss_pkg::STACK_DEPTH-1:0]  hit,
  output logic                             found,
  output logic [lss_pkg::POS_W-1:0]        pos
);

  logic [lss_pkg::NUM_GRP*lss_pkg::GRP-1:0] hit_pad;
  logic [lss_pkg::NUM_GRP-1:0]              grp_any_r;
  logic [lss_pkg::GRP_W-1:0]                grp_idx_r [lss_pkg::NUM_GRP];
  logic [lss_pkg::NUM_GRP-1:0]              grp_any_nxt;
  logic [lss_pkg::GRP_W-1:0]                grp_idx_nxt [lss_pkg::NUM_GRP];

  assign hit_pad = (lss_pkg::NUM_GRP*lss_pkg::GRP)'(hit);

  // First stage: lowest hit inside each group of eight
  always_comb begin
    for (int g = 0; g < lss_pkg::NUM_GRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int k = lss_pkg::GRP - 1; k >= 0; k--) begin
        if (hit_pad[g*lss_pkg::GRP + k]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = lss_pkg::GRP_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < lss_pkg::NUM_GRP; g++) begin
      grp_idx_r[g] <= grp_idx_nxt[g];
    end
  end

  // Second stage: lowest group that holds a hit
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int g = lss_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found = 1'b1;
        pos   = lss_pkg::POS_W'(g * lss_pkg::GRP) + lss_pkg::POS_W'(grp_idx_r[g]);
      end
    end
  end

endmodule

### hdl/lifo_stack_with_search.sv
// Top level: bounded LIFO stack of signed words with value search.
//
// Usage:
//   The input stream carries one operation per transfer: in_tuser selects
//   push, pop or search, in_tdata holds the value to push or to look for.
//   Each input transfer yields exactly one result transfer with the status,
//   the popped or top value, the match position counted from the top, the
//   entry count and an empty flag.
//   The stack is a row of cells; cell 0 is the top. A push shifts the row
//   down, a pop shifts it up, a search compares all cells at once.
//   Push, pop and unused codes present their result in the cycle after the
//   input transfer; a search on a non-empty stack passes the compare register
//   in the cells, the group register of the first-match search and then the
//   output register. One operation is in flight at a time, so push and pop take
//   one item per cycle while the receiver keeps up; a search holds off new input.
//   Reset clears the entry count and the output valid; cell contents are not
//   cleared, since only pushed entries are ever read.
//   When the receiver stalls, the result holds in the output register and no
//   new input is taken until it has been transferred.
module lifo_stack_with_search (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: operand_value[31:0]
  input  logic [31:0] in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: result_value[31:0], match_position[37:32], entry_count[44:38], zero pad
  output logic [47:0] out_tdata,
  // out_tuser: status[1:0], is_empty_flag[2]
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int DEPTH = lss_pkg::STACK_DEPTH;
  localparam int DW    = lss_pkg::DATA_W;
  localparam int CW    = lss_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GROUP  = 3'b010,
    S_SELECT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic signed [DW-1:0]   res_r, res_nxt;
  logic [lss_pkg::OUT_POS_W-1:0] pos_r, pos_nxt;
  logic                   load;

  logic                   accept;
  logic [1:0]             op;
  logic signed [DW-1:0]   value;
  logic                   empty;
  logic                   full;
  logic signed [DW-1:0]   top_value;

  lss_pkg::cell_ctrl_t    ctrl;
  logic signed [DW-1:0]   cell_data [DEPTH];
  logic [DEPTH-1:0]       hit;
  logic [DEPTH-1:0]       occ;
  logic                   found;
  logic [lss_pkg::POS_W-1:0] found_pos;

  assign op        = in_tuser;
  assign value     = in_tdata;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign top_value = empty ? '0 : cell_data[0];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Broadcast shift and compare controls to the row
  always_comb begin
    ctrl.shift_dn  = accept && (op == lss_pkg::OP_PUSH) && !full;
    ctrl.shift_up  = accept && (op == lss_pkg::OP_POP) && !empty;
    ctrl.cmp_en    = accept && (op == lss_pkg::OP_SEARCH);
    ctrl.cmp_value = value;
  end

  // Row of cells, top at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DW-1:0] above;
    logic signed [DW-1:0] below;

    assign occ[i] = (count_r > CW'(i));

    if (i == 0) begin : g_top
      assign above = value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = cell_data[i+1];
    end

    lss_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ[i]),
      .from_above (above),
      .from_below (below),
      .data       (cell_data[i]),
      .hit        (hit[i])
    );
  end

  lss_first_hit u_first_hit (
    .clk   (clk),
    .hit   (hit),
    .found (found),
    .pos   (found_pos)
  );

  // Decode the operation and sequence the search
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    load       = 1'b0;
    status_nxt = lss_pkg::ST_OK;
    res_nxt    = top_value;
    pos_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (op)
            lss_pkg::OP_PUSH: begin
              if (full) begin
                status_nxt = lss_pkg::ST_FULL;
              end else begin
                res_nxt   = value;
                count_nxt = count_r + CW'(1);
              end
            end
            lss_pkg::OP_POP: begin
              if (empty) begin
                status_nxt = lss_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            lss_pkg::OP_SEARCH: begin
              if (empty) begin
                status_nxt = lss_pkg::ST_EMPTY;
              end else begin
                load      = 1'b0;
                state_nxt = S_GROUP;
              end
            end
            default: begin
              res_nxt = top_value;
            end
          endcase
        end
      end
      S_GROUP: begin
        state_nxt = S_SELECT;
      end
      S_SELECT: begin
        load       = 1'b1;
        status_nxt = found ? lss_pkg::ST_OK : lss_pkg::ST_NOT_FOUND;
        pos_nxt    = found ? lss_pkg::OUT_POS_W'(found_pos) : '0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes the transfer
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; count is taken after the operation
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       lss_pkg::OUT_CNT_W'(count_r),
                       pos_r,
                       res_r};
  assign out_tuser  = {(count_r == '0), status_r};

endmodule

### test/tb.sv
// Testbench for lifo_stack_with_search: directed and random push/pop/search traffic with checking.
`timescale 1ns / 100ps

module tb;

  // Unused operation code: block reports the top and changes nothing
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int NUM_RANDOM     = 1350;
  localparam int TAIL_ITEMS     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  position;
    logic [6:0]  count;
    logic        empty;
  } stack_result_t;

  // Mirror of the stack contents plus the results still due from the block
  class lifo_mirror;
    logic [31:0]   cells[lss_pkg::STACK_DEPTH];
    int            depth_held;
    stack_result_t due_results[$];
    int            errors;

    function new();
      depth_held = 0;
      errors     = 0;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(logic [1:0] op, logic [31:0] operand);
      stack_result_t r;
      int            k;
      bit            hit;
      r.status   = lss_pkg::ST_OK;
      r.value    = '0;
      r.position = '0;
      hit        = 1'b0;
      case (op)
        lss_pkg::OP_PUSH: begin
          if (depth_held >= lss_pkg::STACK_DEPTH) begin
            r.status = lss_pkg::ST_FULL;
          end else begin
            cells[depth_held] = operand;
            depth_held++;
          end
        end
        lss_pkg::OP_POP: begin
          if (depth_held == 0) begin
            r.status = lss_pkg::ST_EMPTY;
          end else begin
            r.value = cells[depth_held-1];
            depth_held--;
          end
        end
        lss_pkg::OP_SEARCH: begin
          if (depth_held == 0) begin
            r.status = lss_pkg::ST_EMPTY;
          end else begin
            // scan from the top down, first match wins
            for (k = 0; k < depth_held && !hit; k++) begin
              if (cells[depth_held-1-k] == operand) begin
                hit        = 1'b1;
                r.position = k[5:0];
              end
            end
            r.status = hit ? lss_pkg::ST_OK : lss_pkg::ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      if (op != lss_pkg::OP_POP && depth_held != 0) r.value = cells[depth_held-1];
      r.count = depth_held[6:0];
      r.empty = (depth_held == 0);
      due_results.push_back(r);
    endfunction

    function void report_diff(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    // Compare one result transfer with the oldest outstanding expectation
    function void check_result(logic [47:0] tdata, logic [2:0] tuser);
      stack_result_t r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                 $time, tdata, tuser);
        return;
      end
      r = due_results.pop_front();
      report_diff("status", r.status, tuser[1:0]);
      report_diff("result_value", r.value, tdata[31:0]);
      report_diff("match_position", r.position, tdata[37:32]);
      report_diff("entry_count", r.count, tdata[44:38]);
      report_diff("is_empty_flag", r.empty, tuser[2]);
    endfunction

    // Return a value currently held, so searches find something; a random word if empty
    function logic [31:0] pick_held();
      if (depth_held == 0) return $urandom;
      return cells[$urandom_range(0, depth_held - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  lifo_mirror mirror = new();

  int gap_pct    = 0;
  int stall_pct  = 0;
  bit tail_phase = 1'b0;
  int quiet_cycles = 0;

  lifo_stack_with_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Observe transfers on both sides; results first, they stem from earlier inputs
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata, out_tuser);
    if (rst_n && in_tvalid && in_tready) mirror.note_op(in_tuser, in_tdata);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Present one operation and hold it until the transfer
  task automatic send_op(input logic [1:0] op, input logic [31:0] operand);
    in_tuser  <= op;
    in_tdata  <= operand;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mix of small duplicates, extremes and full-range words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Operation mix per traffic mode: 0 fills, 1 drains, 2 balanced
  function automatic logic [1:0] pick_op(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_NOP;
    case (mode)
      0: return (roll < 75) ? lss_pkg::OP_PUSH :
                (roll < 85) ? lss_pkg::OP_POP : lss_pkg::OP_SEARCH;
      1: return (roll < 20) ? lss_pkg::OP_PUSH :
                (roll < 75) ? lss_pkg::OP_POP : lss_pkg::OP_SEARCH;
      default: return (roll < 40) ? lss_pkg::OP_PUSH :
                      (roll < 70) ? lss_pkg::OP_POP : lss_pkg::OP_SEARCH;
    endcase
  endfunction

  initial begin
    int          i;
    int          mode;
    int          seg_left;
    logic [1:0]  op;
    logic [31:0] operand;

    mode     = 2;
    seg_left = 0;

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack cases, extremes, first match, not found, unused code
    send_op(lss_pkg::OP_POP,    32'h0000_0000);
    send_op(lss_pkg::OP_SEARCH, 32'h0000_0005);
    send_op(OP_NOP,             32'hffff_ffff);
    send_op(lss_pkg::OP_PUSH,   32'h8000_0000);
    send_op(lss_pkg::OP_PUSH,   32'h7fff_ffff);
    send_op(lss_pkg::OP_PUSH,   32'h0000_0000);
    send_op(lss_pkg::OP_PUSH,   32'hffff_ffff);
    send_op(lss_pkg::OP_PUSH,   32'h7fff_ffff);
    send_op(lss_pkg::OP_SEARCH, 32'h7fff_ffff);
    send_op(lss_pkg::OP_SEARCH, 32'h8000_0000);
    send_op(lss_pkg::OP_SEARCH, 32'hffff_ffff);
    send_op(lss_pkg::OP_SEARCH, 32'h0000_3039);
    send_op(OP_NOP,             32'h0000_0000);
    repeat (6) send_op(lss_pkg::OP_POP, 32'h0000_0000);
    send_op(lss_pkg::OP_PUSH,   32'h5555_5555);
    send_op(lss_pkg::OP_PUSH,   32'haaaa_aaaa);
    send_op(lss_pkg::OP_SEARCH, 32'h5555_5555);
    send_op(lss_pkg::OP_POP,    32'h0000_0000);
    send_op(lss_pkg::OP_POP,    32'h0000_0000);

    // Random traffic in segments that fill, drain or churn the stack
    for (i = 0; i < NUM_RANDOM; i++) begin
      if (seg_left == 0) begin
        mode      = $urandom_range(0, 2);
        seg_left  = $urandom_range(40, 150);
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      seg_left--;
      if (i == NUM_RANDOM - TAIL_ITEMS) tail_phase = 1'b1;
      op = pick_op(mode);
      if (op == lss_pkg::OP_SEARCH && $urandom_range(0, 2) != 0)
        operand = mirror.pick_held();
      else
        operand = rand_word();
      send_op(op, operand);
      if (!tail_phase && $urandom_range(0, 99) < gap_pct) idle_input($urandom_range(1, 10));
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then allow for a late extra transfer
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
